### src/dop_pkg.sv
// shared constants, types and command word for the degree ordering block
`default_nettype none
package dop_pkg;

   localparam int MAX_ROWS = 1024;
   localparam int ROW_W    = 10;                       // row / rank / index field
   localparam int RC_W     = 11;                       // row count register
   localparam int DEG_W    = 11;                       // degree field
   localparam int CNT_W    = $clog2(MAX_ROWS + 1);     // counts up to MAX_ROWS
   localparam int LEVELS   = 2 ** DEG_W;               // degree buckets
   localparam logic [RC_W-1:0] ROW_COUNT_RESET = RC_W'(1024);

   typedef enum logic [0:0] {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [ROW_W-1:0]       index;
      logic [DEG_W-1:0]       degree;
      logic                   in_range;   // index below rows in use
      logic                   last;
   } cmd_type;

endpackage
`default_nettype wire

### src/dop_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module dop_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/dop_front.sv
// front end: row count register, word decode and range check
`default_nettype none
module dop_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [dop_pkg::RC_W-1:0]    csr_wr_data,
   input  wire logic                        req_valid,
   input  wire logic                        req_mode,
   input  wire logic [dop_pkg::ROW_W-1:0]   req_index,
   input  wire logic [dop_pkg::DEG_W-1:0]   req_degree,
   input  wire logic                        req_last,
   output      logic                        push_valid,
   output      dop_pkg::cmd_type            push_cmd,
   output      logic [dop_pkg::CNT_W-1:0]   rows_in_use
);

   logic [dop_pkg::RC_W-1:0]  row_count_ff;
   logic [dop_pkg::RC_W-1:0]  row_count_in;
   logic [dop_pkg::CNT_W-1:0] rows_n;

   always_comb begin
      row_count_in = csr_wr_en ? csr_wr_data : row_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= dop_pkg::ROW_COUNT_RESET;
      end else begin
         row_count_ff <= row_count_in;
      end
   end

   // clamp to the table depth
   always_comb begin
      if (32'(row_count_ff) > 32'(dop_pkg::MAX_ROWS)) begin
         rows_n = dop_pkg::CNT_W'(dop_pkg::MAX_ROWS);
      end else begin
         rows_n = dop_pkg::CNT_W'(row_count_ff);
      end
   end

   always_comb begin
      push_cmd.kind     = req_mode ? dop_pkg::CMD_QUERY : dop_pkg::CMD_LOAD;
      push_cmd.index    = req_index;
      push_cmd.degree   = req_degree;
      push_cmd.in_range = dop_pkg::CNT_W'(req_index) < rows_n;
      push_cmd.last     = req_last;
   end

   assign push_valid  = req_valid;
   assign rows_in_use = rows_n;

endmodule
`default_nettype wire

### src/dop_queue.sv
// two word command queue between front and back
`default_nettype none
module dop_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire dop_pkg::cmd_type push_cmd,
   output      logic             push_ready,
   output      logic             head_valid,
   output      dop_pkg::cmd_type head_cmd,
   input  wire logic             pop
);

   dop_pkg::cmd_type slot_ff [2];
   dop_pkg::cmd_type slot_in [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      push_ready = cnt_ff != 2'd2;
      head_valid = cnt_ff != 2'd0;
      head_cmd   = slot_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop && head_valid;
      slot_in    = slot_ff;
      if (do_push) begin
         slot_in[wr_ptr_ff] = push_cmd;
      end
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      unique case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### src/dop_back.sv
// back end: table stores, ranking pass sequencer and result register
`default_nettype none
module dop_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        head_valid,
   input  wire dop_pkg::cmd_type            head_cmd,
   output      logic                        pop,
   input  wire logic [dop_pkg::CNT_W-1:0]   rows_in_use,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [dop_pkg::ROW_W-1:0]   rsp_rank_of_row,
   output      logic [dop_pkg::ROW_W-1:0]   rsp_row_at_rank,
   output      logic                        rsp_out_of_range
);

   localparam int ROW_W = dop_pkg::ROW_W;
   localparam int DEG_W = dop_pkg::DEG_W;
   localparam int CNT_W = dop_pkg::CNT_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_QRY, ST_CLR,
      ST_H_RD, ST_H_BKT, ST_H_WR,
      ST_P_RD, ST_P_WR,
      ST_L_RD, ST_L_BKT, ST_L_WR
   } state_type;

   state_type        state_ff, state_in;
   logic [DEG_W-1:0] lvl_ff, lvl_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] sum_ff, sum_in;
   logic [DEG_W-1:0] deg_ff, deg_in;
   logic             qry_in_range_ff, qry_in_range_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0] rank_ff, rank_in;
   logic [ROW_W-1:0] inv_ff, inv_in;
   logic             oor_ff, oor_in;

   // memory ports
   logic             deg_we, deg_re;
   logic [ROW_W-1:0] deg_waddr, deg_raddr;
   logic [DEG_W-1:0] deg_rdata;
   logic             bkt_we, bkt_re;
   logic [DEG_W-1:0] bkt_waddr, bkt_raddr;
   logic [CNT_W-1:0] bkt_wdata, bkt_rdata;
   logic             rank_we, rank_re;
   logic [ROW_W-1:0] rank_waddr, rank_wdata, rank_rdata;
   logic             inv_we, inv_re;
   logic [ROW_W-1:0] inv_waddr, inv_wdata, inv_rdata;

   logic             last_row;
   logic             last_lvl;

   assign last_row = CNT_W'(row_ff) == (n_ff - CNT_W'(1));
   assign last_lvl = &lvl_ff;

   always_comb begin
      state_in        = state_ff;
      lvl_in          = lvl_ff;
      row_in          = row_ff;
      n_in            = n_ff;
      sum_in          = sum_ff;
      deg_in          = deg_ff;
      qry_in_range_in = qry_in_range_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rank_in         = rank_ff;
      inv_in          = inv_ff;
      oor_in          = oor_ff;
      pop             = 1'b0;
      deg_we          = 1'b0;
      deg_waddr       = head_cmd.index;
      deg_re          = 1'b0;
      deg_raddr       = row_ff;
      bkt_we          = 1'b0;
      bkt_waddr       = lvl_ff;
      bkt_wdata       = '0;
      bkt_re          = 1'b0;
      bkt_raddr       = lvl_ff;
      rank_we         = 1'b0;
      rank_waddr      = row_ff;
      rank_wdata      = bkt_rdata[ROW_W-1:0];
      rank_re         = 1'b0;
      inv_we          = 1'b0;
      inv_waddr       = bkt_rdata[ROW_W-1:0];
      inv_wdata       = row_ff;
      inv_re          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_cmd.kind == dop_pkg::CMD_QUERY) begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     pop             = 1'b1;
                     rank_re         = 1'b1;
                     inv_re          = 1'b1;
                     qry_in_range_in = head_cmd.in_range;
                     state_in        = ST_QRY;
                  end
               end else begin
                  pop    = 1'b1;
                  deg_we = head_cmd.in_range;
                  if (head_cmd.last) begin
                     n_in     = rows_in_use;
                     lvl_in   = '0;
                     state_in = ST_CLR;
                  end
               end
            end
         end
         ST_QRY: begin
            rsp_valid_in = 1'b1;
            rank_in      = qry_in_range_ff ? rank_rdata : '0;
            inv_in       = qry_in_range_ff ? inv_rdata : '0;
            oor_in       = !qry_in_range_ff;
            state_in     = ST_IDLE;
         end
         ST_CLR: begin
            bkt_we = 1'b1;
            lvl_in = lvl_ff + DEG_W'(1);
            if (last_lvl) begin
               row_in   = '0;
               state_in = (n_ff == '0) ? ST_IDLE : ST_H_RD;
            end
         end
         ST_H_RD, ST_L_RD: begin
            deg_re   = 1'b1;
            state_in = (state_ff == ST_H_RD) ? ST_H_BKT : ST_L_BKT;
         end
         ST_H_BKT, ST_L_BKT: begin
            bkt_re    = 1'b1;
            bkt_raddr = deg_rdata;
            deg_in    = deg_rdata;
            state_in  = (state_ff == ST_H_BKT) ? ST_H_WR : ST_L_WR;
         end
         ST_H_WR: begin
            bkt_we    = 1'b1;
            bkt_waddr = deg_ff;
            bkt_wdata = bkt_rdata + CNT_W'(1);
            if (last_row) begin
               lvl_in   = '0;
               sum_in   = '0;
               state_in = ST_P_RD;
            end else begin
               row_in   = row_ff + ROW_W'(1);
               state_in = ST_H_RD;
            end
         end
         ST_P_RD: begin
            bkt_re   = 1'b1;
            state_in = ST_P_WR;
         end
         ST_P_WR: begin
            // bucket becomes its start rank
            bkt_we    = 1'b1;
            bkt_wdata = sum_ff;
            sum_in    = sum_ff + bkt_rdata;
            lvl_in    = lvl_ff + DEG_W'(1);
            if (last_lvl) begin
               row_in   = '0;
               state_in = ST_L_RD;
            end else begin
               state_in = ST_P_RD;
            end
         end
         ST_L_WR: begin
            bkt_we    = 1'b1;
            bkt_waddr = deg_ff;
            bkt_wdata = bkt_rdata + CNT_W'(1);
            rank_we   = 1'b1;
            inv_we    = 1'b1;
            row_in    = row_ff + ROW_W'(1);
            state_in  = last_row ? ST_IDLE : ST_L_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lvl_ff          <= lvl_in;
      row_ff          <= row_in;
      n_ff            <= n_in;
      sum_ff          <= sum_in;
      deg_ff          <= deg_in;
      qry_in_range_ff <= qry_in_range_in;
      rank_ff         <= rank_in;
      inv_ff          <= inv_in;
      oor_ff          <= oor_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   dop_ram #(.WIDTH(DEG_W), .DEPTH(dop_pkg::MAX_ROWS)) u_degree_ram (
      .clock   (clock),
      .wr_en   (deg_we),
      .wr_addr (deg_waddr),
      .wr_data (head_cmd.degree),
      .rd_en   (deg_re),
      .rd_addr (deg_raddr),
      .rd_data (deg_rdata)
   );

   dop_ram #(.WIDTH(CNT_W), .DEPTH(dop_pkg::LEVELS)) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt_we),
      .wr_addr (bkt_waddr),
      .wr_data (bkt_wdata),
      .rd_en   (bkt_re),
      .rd_addr (bkt_raddr),
      .rd_data (bkt_rdata)
   );

   dop_ram #(.WIDTH(ROW_W), .DEPTH(dop_pkg::MAX_ROWS)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_waddr),
      .wr_data (rank_wdata),
      .rd_en   (rank_re),
      .rd_addr (head_cmd.index),
      .rd_data (rank_rdata)
   );

   dop_ram #(.WIDTH(ROW_W), .DEPTH(dop_pkg::MAX_ROWS)) u_inverse_ram (
      .clock   (clock),
      .wr_en   (inv_we),
      .wr_addr (inv_waddr),
      .wr_data (inv_wdata),
      .rd_en   (inv_re),
      .rd_addr (head_cmd.index),
      .rd_data (inv_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rank_of_row  = rank_ff;
   assign rsp_row_at_rank  = inv_ff;
   assign rsp_out_of_range = oor_ff;

endmodule
`default_nettype wire

### src/degree_order_permutation_top.sv
// top level of the degree ordering block: front end, command queue, back end
`default_nettype none
// Degree ordering of matrix rows. Load words (mode 0) write a row degree into
// the degree store; the load word with last set then starts a ranking pass,
// a stable counting sort that gives every row in use a rank by increasing
// degree, ties kept in row order, and fills the rank table and its inverse.
// Query words (mode 1) return the rank of row "index" and the row placed at
// rank "index"; an index not below the rows in use (row_count clamped to the
// table depth) gives out_of_range with both other fields zero. Loads give no
// result word. A load is retired straight from idle; a query goes through the
// table read, then the result register, and the back end takes no new word
// until it is back in idle. The ranking pass holds the back end while it
// clears the degree buckets, counts the rows of each degree, forms the start
// rank of each bucket and places each row, steps all set by the single read
// and write port of the bucket memory. A two word queue sits between the
// input decode and the back end, so input words keep being taken while the
// back end is busy until the queue fills; the result register frees the back
// end as soon as the result word is taken. row_count is written through
// csr_wr_en and csr_wr_data and is meant to change only while the block is
// idle; tables keep the results of the last pass until the next one.
module degree_order_permutation_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // configuration
   input  wire logic                        csr_wr_en,
   input  wire logic [dop_pkg::RC_W-1:0]    csr_wr_data,
   // input words
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic                        req_mode,
   input  wire logic [dop_pkg::ROW_W-1:0]   req_index,
   input  wire logic [dop_pkg::DEG_W-1:0]   req_degree,
   input  wire logic                        req_last,
   // result words
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [dop_pkg::ROW_W-1:0]   rsp_rank_of_row,
   output      logic [dop_pkg::ROW_W-1:0]   rsp_row_at_rank,
   output      logic                        rsp_out_of_range
);

   logic                      push_valid;
   dop_pkg::cmd_type          push_cmd;
   logic [dop_pkg::CNT_W-1:0] rows_in_use;
   logic                      head_valid;
   dop_pkg::cmd_type          head_cmd;
   logic                      pop;

   // decode and range check against the current row count
   dop_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_mode    (req_mode),
      .req_index   (req_index),
      .req_degree  (req_degree),
      .req_last    (req_last),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd),
      .rows_in_use (rows_in_use)
   );

   // input is taken whenever the queue has room
   dop_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (req_ready),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   // tables, ranking pass and result register
   dop_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rows_in_use      (rows_in_use),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rank_of_row  (rsp_rank_of_row),
      .rsp_row_at_rank  (rsp_row_at_rank),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule
`default_nettype wire

### tb/tb_degree_order_permutation_top.sv
`timescale 1ns / 100ps
// testbench for the degree ordering block: loads, ranking passes and rank queries against a predictor
module tb_degree_order_permutation_top;

   localparam int ROW_W    = dop_pkg::ROW_W;
   localparam int RC_W     = dop_pkg::RC_W;
   localparam int DEG_W    = dop_pkg::DEG_W;
   localparam int MAX_ROWS = dop_pkg::MAX_ROWS;
   localparam int LEVELS   = dop_pkg::LEVELS;

   localparam int ITEM_TARGET = 1650;    // stimulus stops once this many words are taken
   localparam int HOLD_CYCLES = 600;     // long receiver hold-off used to fill the block
   localparam int QUIET_LIMIT = 100000;  // cycles with no handshake before giving up

   // one expected result word
   typedef struct packed {
      logic [ROW_W-1:0] rank_of_row;
      logic [ROW_W-1:0] row_at_rank;
      logic             out_of_range;
   } rank_answer_type;

   // tracks degrees, rank table and inverse table, and queues the answers queries should get
   class rank_predictor_type;
      bit [RC_W-1:0]   row_count;
      bit [DEG_W-1:0]  degree_of_row [MAX_ROWS];
      bit [ROW_W-1:0]  rank_of [MAX_ROWS];
      bit [ROW_W-1:0]  row_of [MAX_ROWS];
      bit              degree_known [MAX_ROWS];
      bit              rank_known [MAX_ROWS];
      bit              row_known [MAX_ROWS];
      rank_answer_type answers_due [$];
      int              mismatches;

      function new();
         row_count  = dop_pkg::ROW_COUNT_RESET;
         mismatches = 0;
      endfunction

      function int rows_in_use();
         return (row_count > MAX_ROWS) ? MAX_ROWS : int'(row_count);
      endfunction

      // stable ordering by degree: rows of equal degree keep row order
      function void rank_rows();
         int level_start [LEVELS];
         int n, total, c, d, r;
         n     = rows_in_use();
         total = 0;
         foreach (level_start[k]) level_start[k] = 0;
         for (int i = 0; i < n; i++) level_start[degree_of_row[i]]++;
         for (int k = 0; k < LEVELS; k++) begin
            c              = level_start[k];
            level_start[k] = total;
            total         += c;
         end
         for (int i = 0; i < n; i++) begin
            d = int'(degree_of_row[i]);
            r = level_start[d];
            level_start[d]++;
            rank_of[i]    = r[ROW_W-1:0];
            rank_known[i] = 1'b1;
            row_of[r]     = i[ROW_W-1:0];
            row_known[r]  = 1'b1;
         end
      endfunction

      function bit pass_allowed();
         for (int i = 0; i < rows_in_use(); i++)
            if (!degree_known[i]) return 1'b0;
         return 1'b1;
      endfunction

      function bit query_allowed(bit [ROW_W-1:0] index);
         return (index >= rows_in_use()) || (rank_known[index] && row_known[index]);
      endfunction

      function void note_word(dop_pkg::cmd_kind_type kind, bit [ROW_W-1:0] index,
                              bit [DEG_W-1:0] degree, bit last);
         rank_answer_type answer;
         bit              in_use;
         in_use = index < rows_in_use();
         if (kind == dop_pkg::CMD_LOAD) begin
            if (in_use) begin
               degree_of_row[index] = degree;
               degree_known[index]  = 1'b1;
            end
            if (last) rank_rows();
         end else begin
            answer = '0;
            if (in_use) begin
               answer.rank_of_row = rank_of[index];
               answer.row_at_rank = row_of[index];
            end else begin
               answer.out_of_range = 1'b1;
            end
            answers_due = {answers_due, answer};
         end
      endfunction

      function void check_word(logic [ROW_W-1:0] rank, logic [ROW_W-1:0] row, logic oor);
         rank_answer_type want;
         if (answers_due.size() == 0) begin
            $error("result word arrived with no query waiting");
            mismatches++;
            return;
         end
         want = answers_due.pop_front();
         if (rank !== want.rank_of_row) begin
            $error("rank_of_row: expected %0d, got %0d", want.rank_of_row, rank);
            mismatches++;
         end
         if (row !== want.row_at_rank) begin
            $error("row_at_rank: expected %0d, got %0d", want.row_at_rank, row);
            mismatches++;
         end
         if (oor !== want.out_of_range) begin
            $error("out_of_range: expected %0d, got %0d", want.out_of_range, oor);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [RC_W-1:0]   csr_wr_data;
   logic              req_valid;
   logic              req_ready;
   logic              req_mode;
   logic [ROW_W-1:0]  req_index;
   logic [DEG_W-1:0]  req_degree;
   logic              req_last;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [ROW_W-1:0]  rsp_rank_of_row;
   logic [ROW_W-1:0]  rsp_row_at_rank;
   logic              rsp_out_of_range;

   rank_predictor_type ranks = new();
   bit                 idle_on;        // random gaps on both sides while set
   bit                 hold_results;   // asks the receiver for one long hold-off
   int                 words_sent;
   int                 quiet_cycles = 0;

   degree_order_permutation_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_index        (req_index),
      .req_degree       (req_degree),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rank_of_row  (rsp_rank_of_row),
      .rsp_row_at_rank  (rsp_row_at_rank),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
   endfunction

   // small degrees give plenty of ties, the rest covers the whole field and its ends
   function automatic logic [DEG_W-1:0] pick_degree();
      case ($urandom_range(0, 3))
         0: return DEG_W'($urandom_range(0, LEVELS - 1));
         3: return $urandom_range(0, 1) ? {DEG_W{1'b1}} : {DEG_W{1'b0}};
         default: return DEG_W'($urandom_range(0, 7));
      endcase
   endfunction

   // mostly rows in use, one in eight beyond them
   function automatic logic [ROW_W-1:0] load_index(int n);
      if (n == 0 || (n < MAX_ROWS && $urandom_range(0, 7) == 0))
         return ROW_W'($urandom_range(n, MAX_ROWS - 1));
      return ROW_W'($urandom_range(0, n - 1));
   endfunction

   // never read a table entry that no pass has written
   function automatic logic [ROW_W-1:0] query_index(int n);
      logic [ROW_W-1:0] idx;
      idx = load_index(n);
      if (!ranks.query_allowed(idx) && n < MAX_ROWS)
         idx = ROW_W'($urandom_range(n, MAX_ROWS - 1));
      return idx;
   endfunction

   // time to wait for a ranking pass, which gives no result word
   function automatic int pass_cycles();
      return 6144 + 6 * ranks.rows_in_use() + 100;
   endfunction

   // offer one word, hold it until taken, then tell the predictor
   task automatic send_word(dop_pkg::cmd_kind_type kind, logic [ROW_W-1:0] index,
                            logic [DEG_W-1:0] degree, logic last);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? idle_length() : 0;
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_mode   <= kind;
      req_index  <= index;
      req_degree <= degree;
      req_last   <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ranks.note_word(kind, index, degree, last);
      words_sent++;
   endtask

   task automatic release_bus();
      @(negedge clock) req_valid <= 1'b0;
   endtask

   // all answers in, then time for a pass that may still be running
   task automatic wait_drained();
      while (ranks.answers_due.size() != 0) @(posedge clock);
      repeat (pass_cycles()) @(negedge clock);
   endtask

   // row_count only changes while the block is idle
   task automatic write_row_count(logic [RC_W-1:0] value);
      release_bus();
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock) csr_wr_en <= 1'b0;
      ranks.row_count = value;
   endtask

   task automatic run_directed();
      write_row_count(RC_W'(4));
      // field extremes and a tie between rows 0 and 1
      send_word(dop_pkg::CMD_LOAD, ROW_W'(2), {DEG_W{1'b1}}, 1'b0);
      send_word(dop_pkg::CMD_LOAD, ROW_W'(0), DEG_W'(5), 1'b0);
      send_word(dop_pkg::CMD_LOAD, ROW_W'(3), DEG_W'(0), 1'b0);
      // beyond rows in use, dropped
      send_word(dop_pkg::CMD_LOAD, {ROW_W{1'b1}}, DEG_W'(9), 1'b0);
      send_word(dop_pkg::CMD_LOAD, ROW_W'(1), DEG_W'(5), 1'b0);
      // out of range but still starts the pass
      send_word(dop_pkg::CMD_LOAD, ROW_W'(1000), DEG_W'(3), 1'b1);
      // last on a query has no effect
      for (int i = 0; i < 4; i++) send_word(dop_pkg::CMD_QUERY, ROW_W'(i), DEG_W'(0), i[0]);
      send_word(dop_pkg::CMD_QUERY, ROW_W'(4), {DEG_W{1'b1}}, 1'b0);
      send_word(dop_pkg::CMD_QUERY, {ROW_W{1'b1}}, DEG_W'(0), 1'b1);
      // no rows in use: everything out of range, the pass leaves the tables alone
      write_row_count(RC_W'(0));
      send_word(dop_pkg::CMD_QUERY, ROW_W'(0), DEG_W'(0), 1'b0);
      send_word(dop_pkg::CMD_LOAD, ROW_W'(0), DEG_W'(7), 1'b1);
      send_word(dop_pkg::CMD_QUERY, ROW_W'(0), DEG_W'(0), 1'b0);
      // one row: first a stale read of the rank and inverse tables, then a fresh pass
      write_row_count(RC_W'(1));
      send_word(dop_pkg::CMD_QUERY, ROW_W'(0), DEG_W'(0), 1'b0);
      send_word(dop_pkg::CMD_LOAD, ROW_W'(0), DEG_W'(1), 1'b1);
      send_word(dop_pkg::CMD_QUERY, ROW_W'(0), DEG_W'(0), 1'b0);
      send_word(dop_pkg::CMD_QUERY, ROW_W'(1), DEG_W'(0), 1'b0);
   endtask

   // every row loaded once in shuffled order, then queries over the whole table
   task automatic run_full_table();
      int order [MAX_ROWS];
      int j, t;
      write_row_count(RC_W'(MAX_ROWS));
      for (int i = 0; i < MAX_ROWS; i++) order[i] = i;
      for (int i = MAX_ROWS - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < MAX_ROWS; i++)
         send_word(dop_pkg::CMD_LOAD, order[i][ROW_W-1:0], pick_degree(), i == MAX_ROWS - 1);
      repeat (120)
         send_word(dop_pkg::CMD_QUERY, ROW_W'($urandom_range(0, MAX_ROWS - 1)),
                   DEG_W'($urandom_range(0, LEVELS - 1)), 1'($urandom_range(0, 1)));
   endtask

   // a burst of loads, closed by last once every row in use has a degree, then queries;
   // under pressure the pass is skipped so that results pile up behind the held receiver
   task automatic run_round(bit pressure);
      int n, loads, queries;
      n     = ranks.rows_in_use();
      loads = $urandom_range(1, (n < 10) ? n + 2 : 12);
      for (int k = 0; k < loads; k++)
         send_word(dop_pkg::CMD_LOAD, load_index(n), pick_degree(),
                   !pressure && k == loads - 1 && ranks.pass_allowed());
      if (pressure) hold_results = 1'b1;
      queries = pressure ? 40 : $urandom_range(4, 16);
      repeat (queries)
         send_word(dop_pkg::CMD_QUERY, query_index(n), DEG_W'($urandom_range(0, LEVELS - 1)),
                   1'($urandom_range(0, 1)));
      // stray load after the pass: tables stay stale until the next one
      if ($urandom_range(0, 3) == 0) begin
         send_word(dop_pkg::CMD_LOAD, load_index(n), pick_degree(), 1'b0);
         send_word(dop_pkg::CMD_QUERY, query_index(n), DEG_W'(0), 1'b0);
      end
   endtask

   // receiver: random stalls, plus one long hold-off counted here on request
   initial begin
      int hold_left;
      int stall_left;
      bit hold_done;
      hold_left  = 0;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) stall_left = idle_length();
         end
      end
   end

   // every result word taken goes to the checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ranks.check_word(rsp_rank_of_row, rsp_row_at_rank, rsp_out_of_range);
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [RC_W-1:0] extreme_counts [4];
      logic [RC_W-1:0] count;
      int              phase_no;
      extreme_counts = '{RC_W'(2047), RC_W'(1023), RC_W'(2), RC_W'(3)};
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_valid    = 1'b0;
      req_mode     = 1'b0;
      req_index    = '0;
      req_degree   = '0;
      req_last     = 1'b0;
      idle_on      = 1'b1;
      hold_results = 1'b0;
      words_sent   = 0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      run_directed();
      // once every row has a degree, any later pass reads only written entries
      run_full_table();

      // mixed phases: register extremes first, then mostly small row counts
      phase_no = 0;
      while (words_sent < ITEM_TARGET) begin
         if (phase_no < 4)
            count = extreme_counts[phase_no];
         else
            count = ($urandom_range(0, 9) == 0) ? RC_W'(0) : RC_W'($urandom_range(1, 48));
         write_row_count(count);
         idle_on = ($urandom_range(0, 3) != 0);
         run_round(phase_no == 2);
         run_round(1'b0);
         phase_no++;
      end

      release_bus();
      wait_drained();
      if (ranks.mismatches == 0 && ranks.answers_due.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
src/dop_pkg.sv
src/dop_ram.sv
src/dop_front.sv
src/dop_queue.sv
src/dop_back.sv
src/degree_order_permutation_top.sv
tb/tb_degree_order_permutation_top.sv
